### rtl/grid_ray_traversal_core_assert.svh
// Assertion macros used by the port-level checker of the grid ray traversal core.
`ifndef GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH
`define GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH

// Consequent in the cycle after the antecedent, ignored while reset is applied.
`define GRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid ray traversal core: assertion failed");

// Consequent in the cycle after the antecedent, checked during reset as well.
`define GRT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grid ray traversal core: assertion failed");

`endif

### rtl/grt_pkg.sv
// Shared types and constants of the grid ray traversal core.
package grt_pkg;

  localparam int COORD_W       = 22;
  localparam int CELL_W        = 12;
  localparam int TYPE_W        = 8;
  localparam int DIM_W         = 7;
  localparam int TSIZE_W       = 8;
  localparam int MAP_CELLS_DEF = 4096;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MULA_W        = 26;
  localparam int MULB_W        = 24;
  localparam int PROD_W        = MULA_W + MULB_W;
  localparam int DIV_NW        = 48;
  localparam int DIV_DW        = 24;
  localparam int DIV_CNT_W     = 6;
  localparam int IDX_W         = 17;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;

  localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TILE_SIZE  = 3'd2;
  localparam logic [2:0] REG_WALL       = 3'd3;
  localparam logic [2:0] REG_ENEMY_WALL = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   map_width;
    logic [DIM_W-1:0]   map_height;
    logic [TSIZE_W-1:0] tile_size;
    logic [TYPE_W-1:0]  wall_type;
    logic [TYPE_W-1:0]  enemy_wall_type;
  } grt_cfg_t;

  typedef struct packed {
    logic [MULA_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
  } grt_unit_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              div_done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } grt_unit_rsp_t;

  typedef struct packed {
    logic               path_clear;
    logic [COORD_W-1:0] stop_x;
    logic [COORD_W-1:0] stop_y;
    logic               tile_valid;
    logic [CELL_W-1:0]  last_tile;
  } grt_res_t;

endpackage

### rtl/grt_if.sv
// Request and result channel interfaces of the grid ray traversal core.
interface grt_in_if import grt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CELL_W-1:0]  cell_index;
  logic [TYPE_W-1:0]  cell_type;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  modport source (output valid, kind, cell_index, cell_type, origin_x, origin_y,
                  target_x, target_y, input ready);
  modport sink (input valid, kind, cell_index, cell_type, origin_x, origin_y,
                target_x, target_y, output ready);
endinterface

interface grt_out_if import grt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               path_clear;
  logic [COORD_W-1:0] stop_x;
  logic [COORD_W-1:0] stop_y;
  logic               tile_valid;
  logic [CELL_W-1:0]  last_tile;
  modport source (output valid, path_clear, stop_x, stop_y, tile_valid, last_tile,
                  input ready);
  modport sink (input valid, path_clear, stop_x, stop_y, tile_valid, last_tile,
                output ready);
endinterface

### rtl/grt_tile_ram.sv
// Tile type map memory with one write port and one registered read port.
module grt_tile_ram import grt_pkg::*; #(
  parameter int DEPTH = MAP_CELLS_DEF,
  parameter int AW    = $clog2(MAP_CELLS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [TYPE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [TYPE_W-1:0] rdata_r
);

  logic [TYPE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/grt_unit.sv
// Shared arithmetic unit: registered multiplier and a restoring bit-serial divider.
module grt_unit import grt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  grt_unit_req_t req,
  output grt_unit_rsp_t rsp
);

  logic [PROD_W-1:0]    prod_r;
  logic [DIV_NW-1:0]    quo_r, quo_nxt;
  logic [DIV_DW-1:0]    rem_r, rem_nxt;
  logic [DIV_DW-1:0]    den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DW:0]      shifted;
  logic [DIV_DW:0]      diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_NW-1]};
    diff     = shifted - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.div_start) begin
      quo_nxt  = req.div_num;
      rem_nxt  = '0;
      den_nxt  = req.div_den;
      cnt_nxt  = DIV_CNT_W'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_DW]) begin
        rem_nxt = diff[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    prod_r <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.prod     = prod_r;
  assign rsp.div_done = done_r;
  assign rsp.quo      = quo_r;
  assign rsp.rem      = rem_r;

endmodule

### rtl/grt_seq.sv
// Sequencer of one cast: tile setup, grid walk, tile tests and stop point.
module grt_seq import grt_pkg::*; #(
  parameter int MAP_CELLS = MAP_CELLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int AW        = $clog2(MAP_CELLS_DEF)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  grt_cfg_t           cfg,
  input  logic               start,
  input  logic [COORD_W-1:0] origin_x,
  input  logic [COORD_W-1:0] origin_y,
  input  logic [COORD_W-1:0] target_x,
  input  logic [COORD_W-1:0] target_y,
  output logic               idle,
  output grt_unit_req_t      unit_req,
  input  grt_unit_rsp_t      unit_rsp,
  output logic [AW-1:0]      raddr,
  input  logic [TYPE_W-1:0]  rdata,
  output logic               res_pending,
  input  logic               res_ack,
  output grt_res_t           res
);

  localparam int TW = TSIZE_W + FRAC_BITS;
  localparam int CW = COORD_W - FRAC_BITS + 3;
  localparam int SW = COORD_W + 4;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DXG  = 15'b000000000000010,
    S_DXW  = 15'b000000000000100,
    S_DYG  = 15'b000000000001000,
    S_DYW  = 15'b000000000010000,
    S_TIDX = 15'b000000000100000,
    S_TRD  = 15'b000000001000000,
    S_TCHK = 15'b000000010000000,
    S_MULA = 15'b000000100000000,
    S_MULB = 15'b000001000000000,
    S_STEP = 15'b000010000000000,
    S_MULO = 15'b000100000000000,
    S_DOG  = 15'b001000000000000,
    S_DOW  = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [COORD_W-1:0] ox_r, oy_r, tx_r, ty_r, adx_r, ady_r;
  logic [COORD_W-1:0] ox_nxt, oy_nxt, tx_nxt, ty_nxt, adx_nxt, ady_nxt;
  logic               sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic [TW-1:0]      t_r, t_nxt;
  logic signed [CW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [MULA_W-1:0]  nx_r, ny_r, n_r, nx_nxt, ny_nxt, n_nxt;
  logic               stepx_r, stepx_nxt;
  logic               orig_r, orig_nxt;
  logic               inmap_r, inmap_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt, idx_w;
  logic [PROD_W-1:0]  pa_r, pa_nxt;
  grt_res_t           res_r, res_nxt;
  logic               stepx_w, blk;
  logic [MULA_W-1:0]  n_w;
  logic [COORD_W-1:0] ad_w, adj_w;
  logic [TSIZE_W-1:0] ts_w;

  function automatic logic [COORD_W-1:0] sat_along(input logic [COORD_W-1:0] o,
                                                   input logic neg,
                                                   input logic [SW-3:0] m);
    logic signed [SW-1:0] v;
    if (neg) begin
      v = $signed({2'b00, o}) - $signed({2'b00, m});
    end else begin
      v = $signed({2'b00, o}) + $signed({2'b00, m});
    end
    if (v < 0) begin
      return '0;
    end else if (v > $signed(SW'({COORD_W{1'b1}}))) begin
      return {COORD_W{1'b1}};
    end
    return v[COORD_W-1:0];
  endfunction

  assign idle        = (state_r == S_IDLE);
  assign res_pending = (state_r == S_DONE);
  assign res         = res_r;
  assign idx_w       = IDX_W'(unit_rsp.prod[13:0]) + IDX_W'(cx_r[DIM_W-1:0]);
  assign raddr       = AW'(idx_w);
  assign blk         = inmap_r && (rdata == cfg.wall_type || rdata == cfg.enemy_wall_type);
  assign stepx_w     = (ady_r == '0) ||
                       (adx_r != '0 && pa_r < unit_rsp.prod);
  assign n_w         = stepx_w ? nx_r : ny_r;
  assign ad_w        = stepx_w ? adx_r : ady_r;
  assign adj_w       = stepx_r ? adx_r : ady_r;
  assign ts_w        = (cfg.tile_size == '0) ? TSIZE_W'(1) : cfg.tile_size;

  always_comb begin
    state_nxt = state_r;
    ox_nxt = ox_r; oy_nxt = oy_r; tx_nxt = tx_r; ty_nxt = ty_r;
    adx_nxt = adx_r; ady_nxt = ady_r; sxn_nxt = sxn_r; syn_nxt = syn_r;
    t_nxt = t_r; cx_nxt = cx_r; cy_nxt = cy_r;
    nx_nxt = nx_r; ny_nxt = ny_r; n_nxt = n_r;
    stepx_nxt = stepx_r; orig_nxt = orig_r; inmap_nxt = inmap_r;
    idx_nxt = idx_r; pa_nxt = pa_r; res_nxt = res_r;
    unit_req = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ox_nxt  = origin_x; oy_nxt = origin_y;
          tx_nxt  = target_x; ty_nxt = target_y;
          sxn_nxt = target_x < origin_x;
          syn_nxt = target_y < origin_y;
          adx_nxt = (target_x < origin_x) ? origin_x - target_x : target_x - origin_x;
          ady_nxt = (target_y < origin_y) ? origin_y - target_y : target_y - origin_y;
          t_nxt   = {ts_w, {FRAC_BITS{1'b0}}};
          orig_nxt = 1'b1;
          res_nxt.path_clear = 1'b1;
          res_nxt.stop_x     = target_x;
          res_nxt.stop_y     = target_y;
          res_nxt.tile_valid = 1'b0;
          res_nxt.last_tile  = '0;
          state_nxt = S_DXG;
        end
      end
      S_DXG: begin
        unit_req.div_start = 1'b1;
        unit_req.div_num   = DIV_NW'(ox_r);
        unit_req.div_den   = DIV_DW'(t_r);
        state_nxt = S_DXW;
      end
      S_DXW: begin
        if (unit_rsp.div_done) begin
          cx_nxt = CW'(unit_rsp.quo);
          nx_nxt = sxn_r ? MULA_W'(unit_rsp.rem) : MULA_W'(t_r) - MULA_W'(unit_rsp.rem);
          state_nxt = S_DYG;
        end
      end
      S_DYG: begin
        unit_req.div_start = 1'b1;
        unit_req.div_num   = DIV_NW'(oy_r);
        unit_req.div_den   = DIV_DW'(t_r);
        state_nxt = S_DYW;
      end
      S_DYW: begin
        if (unit_rsp.div_done) begin
          cy_nxt = CW'(unit_rsp.quo);
          ny_nxt = syn_r ? MULA_W'(unit_rsp.rem) : MULA_W'(t_r) - MULA_W'(unit_rsp.rem);
          state_nxt = S_TIDX;
        end
      end
      S_TIDX: begin
        unit_req.mul_a = MULA_W'(cy_r[DIM_W-1:0]);
        unit_req.mul_b = MULB_W'(cfg.map_width);
        inmap_nxt = (cx_r >= 0) && (cy_r >= 0) &&
                    (cx_r < $signed(CW'(cfg.map_width))) &&
                    (cy_r < $signed(CW'(cfg.map_height)));
        state_nxt = S_TRD;
      end
      S_TRD: begin
        idx_nxt   = idx_w;
        inmap_nxt = inmap_r && (idx_w < IDX_W'(MAP_CELLS));
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        orig_nxt = 1'b0;
        if (orig_r) begin
          if (blk) begin
            res_nxt.path_clear = 1'b0;
            res_nxt.stop_x     = ox_r;
            res_nxt.stop_y     = oy_r;
            res_nxt.tile_valid = 1'b1;
            res_nxt.last_tile  = CELL_W'(idx_r);
            state_nxt = S_DONE;
          end else if (ox_r == tx_r && oy_r == ty_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MULA;
          end
        end else begin
          if (inmap_r) begin
            res_nxt.tile_valid = 1'b1;
            res_nxt.last_tile  = CELL_W'(idx_r);
          end
          state_nxt = blk ? S_MULO : S_MULA;
        end
      end
      S_MULA: begin
        unit_req.mul_a = nx_r;
        unit_req.mul_b = MULB_W'(ady_r);
        state_nxt = S_MULB;
      end
      S_MULB: begin
        unit_req.mul_a = ny_r;
        unit_req.mul_b = MULB_W'(adx_r);
        pa_nxt = unit_rsp.prod;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        stepx_nxt = stepx_w;
        n_nxt     = n_w;
        if (stepx_w) begin
          cx_nxt = sxn_r ? cx_r - CW'(1) : cx_r + CW'(1);
          nx_nxt = nx_r + MULA_W'(t_r);
        end else begin
          cy_nxt = syn_r ? cy_r - CW'(1) : cy_r + CW'(1);
          ny_nxt = ny_r + MULA_W'(t_r);
        end
        state_nxt = (n_w >= MULA_W'(ad_w)) ? S_DONE : S_TIDX;
      end
      S_MULO: begin
        unit_req.mul_a = n_r;
        unit_req.mul_b = MULB_W'(stepx_r ? ady_r : adx_r);
        state_nxt = S_DOG;
      end
      S_DOG: begin
        unit_req.div_start = 1'b1;
        unit_req.div_num   = DIV_NW'({unit_rsp.prod, 1'b0}) + DIV_NW'(adj_w);
        unit_req.div_den   = DIV_DW'({adj_w, 1'b0});
        state_nxt = S_DOW;
      end
      S_DOW: begin
        if (unit_rsp.div_done) begin
          res_nxt.path_clear = 1'b0;
          if (stepx_r) begin
            res_nxt.stop_x = sat_along(ox_r, sxn_r, (SW-2)'(n_r));
            res_nxt.stop_y = sat_along(oy_r, syn_r, (SW-2)'(unit_rsp.quo));
          end else begin
            res_nxt.stop_x = sat_along(ox_r, sxn_r, (SW-2)'(unit_rsp.quo));
            res_nxt.stop_y = sat_along(oy_r, syn_r, (SW-2)'(n_r));
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ox_r <= ox_nxt; oy_r <= oy_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
    adx_r <= adx_nxt; ady_r <= ady_nxt; sxn_r <= sxn_nxt; syn_r <= syn_nxt;
    t_r <= t_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt; n_r <= n_nxt;
    stepx_r <= stepx_nxt; orig_r <= orig_nxt; inmap_r <= inmap_nxt;
    idx_r <= idx_nxt; pa_r <= pa_nxt; res_r <= res_nxt;
  end

endmodule

### rtl/grid_ray_traversal_core.sv
// Top level of the grid ray traversal core: configuration, map, sequencer, result register.
//
// Requests arrive on in_ch. A map write request (kind 0) stores cell_type
// at cell_index and produces no result. A cast request
// (kind 1) produces exactly one result on out_ch.
// A cast runs a setup, two 48-step divisions of the origin by the tile size on
// the shared divider, then for each tile crossed three multiplies on the shared
// multiplier, one map read and the test, and on a wall hit a further division
// that places the stop point.
// in_ch.ready is low for the whole cast; one cast runs at a time.
// The result waits in an output register; a new request is taken while it
// waits, and a following cast holds its result until out_ch is drained.
// Registers are written over the APB port at byte address 4*index.
// Reset returns the registers to their defaults and empties the result
// register; the tile map is not cleared and holds no defined value until
// written.
module grid_ray_traversal_core import grt_pkg::*; #(
  parameter int MAP_CELLS = MAP_CELLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  grt_in_if.sink            in_ch,
  grt_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(MAP_CELLS);

  grt_cfg_t      cfg_r;
  grt_unit_req_t unit_req;
  grt_unit_rsp_t unit_rsp;
  grt_res_t      res, out_r;
  logic          out_valid_r;
  logic          idle, res_pending, res_ack, in_acc, map_we, cfg_we;
  logic [AW-1:0] raddr;
  logic [TYPE_W-1:0] rdata;
  logic [2:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_width       <= DIM_W'(64);
      cfg_r.map_height      <= DIM_W'(64);
      cfg_r.tile_size       <= TSIZE_W'(32);
      cfg_r.wall_type       <= TYPE_W'(1);
      cfg_r.enemy_wall_type <= TYPE_W'(2);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAP_WIDTH:  cfg_r.map_width       <= cfg_pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: cfg_r.map_height      <= cfg_pwdata[DIM_W-1:0];
        REG_TILE_SIZE:  cfg_r.tile_size       <= cfg_pwdata[TSIZE_W-1:0];
        REG_WALL:       cfg_r.wall_type       <= cfg_pwdata[TYPE_W-1:0];
        REG_ENEMY_WALL: cfg_r.enemy_wall_type <= cfg_pwdata[TYPE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAP_WIDTH:  cfg_prdata = CFG_DW'(cfg_r.map_width);
      REG_MAP_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.map_height);
      REG_TILE_SIZE:  cfg_prdata = CFG_DW'(cfg_r.tile_size);
      REG_WALL:       cfg_prdata = CFG_DW'(cfg_r.wall_type);
      REG_ENEMY_WALL: cfg_prdata = CFG_DW'(cfg_r.enemy_wall_type);
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = idle;
  assign in_acc      = in_ch.valid && idle;
  assign map_we      = in_acc && (in_ch.kind == KIND_WRITE) &&
                       (IDX_W'(in_ch.cell_index) < IDX_W'(MAP_CELLS));

  grt_tile_ram #(.DEPTH(MAP_CELLS), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (map_we),
    .waddr   (AW'(in_ch.cell_index)),
    .wdata   (in_ch.cell_type),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  grt_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .rsp   (unit_rsp)
  );

  grt_seq #(.MAP_CELLS(MAP_CELLS), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .start       (in_acc && (in_ch.kind == KIND_CAST)),
    .origin_x    (in_ch.origin_x),
    .origin_y    (in_ch.origin_y),
    .target_x    (in_ch.target_x),
    .target_y    (in_ch.target_y),
    .idle        (idle),
    .unit_req    (unit_req),
    .unit_rsp    (unit_rsp),
    .raddr       (raddr),
    .rdata       (rdata),
    .res_pending (res_pending),
    .res_ack     (res_ack),
    .res         (res)
  );

  assign res_ack = res_pending && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_ack) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_clear = out_r.path_clear;
  assign out_ch.stop_x     = out_r.stop_x;
  assign out_ch.stop_y     = out_r.stop_y;
  assign out_ch.tile_valid = out_r.tile_valid;
  assign out_ch.last_tile  = out_r.last_tile;

endmodule

### rtl/grt_checker.sv
// Port-level checker of the grid ray traversal core and its bind statement.
`include "grid_ray_traversal_core_assert.svh"
module grt_checker import grt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_stop_x,
  input logic [COORD_W-1:0] out_stop_y
);

  `GRT_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  `GRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_stop_x) && $stable(out_stop_y))
  `GRT_ASSERT_NEXT(a_cast_busy, clk, rst_n, in_valid && in_ready && in_kind == KIND_CAST, !in_ready)
  `GRT_ASSERT_NEXT(a_write_silent, clk, rst_n, in_valid && in_ready && in_kind == KIND_WRITE && !out_valid, !out_valid)

endmodule

bind grid_ray_traversal_core grt_checker u_grt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_stop_x (out_ch.stop_x),
  .out_stop_y (out_ch.stop_y)
);

### tb/grt_scoreboard.sv
// Scoreboard class: predicts grid ray traversal results and checks them in order.
`timescale 1ns / 1ps
class grt_scoreboard;
  logic [7:0] tile_map [0:4095];
  int unsigned map_width, map_height, tile_size, wall_type, enemy_wall_type;
  grt_pkg::grt_res_t pending [$];
  int unsigned errors;

  function void reset_state();
    map_width = 64;
    map_height = 64;
    tile_size = 32;
    wall_type = 1;
    enemy_wall_type = 2;
    pending.delete();
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      grt_pkg::REG_MAP_WIDTH: map_width = value[6:0];
      grt_pkg::REG_MAP_HEIGHT: map_height = value[6:0];
      grt_pkg::REG_TILE_SIZE: tile_size = value[7:0];
      grt_pkg::REG_WALL: wall_type = value[7:0];
      grt_pkg::REG_ENEMY_WALL: enemy_wall_type = value[7:0];
      default: ;
    endcase
  endfunction

  function bit in_map(longint cx, longint cy, output int unsigned idx);
    longint i;
    if (cx < 0 || cy < 0 || cx >= map_width || cy >= map_height) return 0;
    i = cy * map_width + cx;
    if (i >= 4096) return 0;
    idx = i;
    return 1;
  endfunction

  function bit blocks(int unsigned idx);
    return tile_map[idx] == wall_type || tile_map[idx] == enemy_wall_type;
  endfunction

  function longint unsigned clamp(longint v);
    if (v < 0) return 0;
    if (v > 4194303) return 4194303;
    return v;
  endfunction

  function void note_request(logic kind, logic [11:0] ci, logic [7:0] ct,
                             logic [21:0] oxi, logic [21:0] oyi,
                             logic [21:0] txi, logic [21:0] tyi);
    longint ox, oy, tx, ty, sx, sy, cx, cy, tl;
    longint unsigned adx, ady, nx, ny, n, ad, oth;
    int unsigned idx, last;
    bit valid, stepx;
    grt_pkg::grt_res_t r;
    if (kind == grt_pkg::KIND_WRITE) begin
      tile_map[ci] = ct;
      return;
    end
    ox = oxi; oy = oyi; tx = txi; ty = tyi;
    tl = (tile_size == 0 ? 1 : tile_size) << 8;
    cx = ox / tl;
    cy = oy / tl;
    r = '{1'b1, txi, tyi, 1'b0, 12'd0};
    valid = 0;
    last = 0;
    if (in_map(cx, cy, idx) && blocks(idx)) begin
      r = '{1'b0, oxi, oyi, 1'b1, idx[11:0]};
      pending = {pending, r};
      return;
    end
    if (ox == tx && oy == ty) begin
      pending = {pending, r};
      return;
    end
    sx = tx < ox ? -1 : 1;
    sy = ty < oy ? -1 : 1;
    adx = tx < ox ? ox - tx : tx - ox;
    ady = ty < oy ? oy - ty : ty - oy;
    nx = sx > 0 ? tl - ox % tl : ox % tl;
    ny = sy > 0 ? tl - oy % tl : oy % tl;
    forever begin
      stepx = (ady == 0) || (adx != 0 && nx * ady < ny * adx);
      if (stepx) begin
        cx += sx; n = nx; ad = adx; nx += tl;
      end else begin
        cy += sy; n = ny; ad = ady; ny += tl;
      end
      if (n >= ad) break;
      if (in_map(cx, cy, idx)) begin
        valid = 1;
        last = idx;
        if (blocks(idx)) begin
          r.path_clear = 0;
          if (stepx) begin
            oth = (2 * n * ady + adx) / (2 * adx);
            r.stop_x = clamp(sx > 0 ? ox + n : ox - n);
            r.stop_y = clamp(sy > 0 ? oy + oth : oy - oth);
          end else begin
            oth = (2 * n * adx + ady) / (2 * ady);
            r.stop_x = clamp(sx > 0 ? ox + oth : ox - oth);
            r.stop_y = clamp(sy > 0 ? oy + n : oy - n);
          end
          break;
        end
      end
    end
    r.tile_valid = valid;
    r.last_tile = valid ? last[11:0] : 12'd0;
    pending = {pending, r};
  endfunction

  function void check_result(grt_pkg::grt_res_t got);
    grt_pkg::grt_res_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

### tb/testbench.sv
// Top-level testbench of the grid ray traversal core.
`timescale 1ns / 1ps
module testbench;
  import grt_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;
  grt_in_if in_ch ();
  grt_out_if out_ch ();
  grt_scoreboard ray_board = new();
  bit written [0:4095];
  int unsigned wr_cells [$];

  grid_ray_traversal_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  initial begin
    #2_000_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function int unsigned pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ray_board.check_result('{out_ch.path_clear, out_ch.stop_x, out_ch.stop_y,
                               out_ch.tile_valid, out_ch.last_tile});
  end

  initial begin
    int unsigned g;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (g > 0) begin
        out_ch.ready <= 0;
        g--;
      end else begin
        out_ch.ready <= 1;
        g = pick_gap();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= CFG_AW'(idx) << 2; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    ray_board.set_reg(idx, value);
  endtask

  task automatic send(logic kind, logic [11:0] ci, logic [7:0] ct, logic [21:0] ox,
                      logic [21:0] oy, logic [21:0] tx, logic [21:0] ty);
    int unsigned g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_ch.valid <= 0;
    end
    @(negedge clk);
    in_ch.valid <= 1; in_ch.kind <= kind; in_ch.cell_index <= ci;
    in_ch.cell_type <= ct; in_ch.origin_x <= ox; in_ch.origin_y <= oy;
    in_ch.target_x <= tx; in_ch.target_y <= ty;
    do @(posedge clk); while (!in_ch.ready);
    ray_board.note_request(kind, ci, ct, ox, oy, tx, ty);
    if (kind == KIND_WRITE && !written[ci]) begin
      written[ci] = 1;
      wr_cells = {wr_cells, 32'(ci)};
    end
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    int unsigned w;
    w = 0;
    while (ray_board.pending.size() != 0 && w < 2_000_000) begin
      @(posedge clk);
      w++;
    end
    if (w >= 2_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic fill_map(int unsigned wd, int unsigned ht, int unsigned density);
    int unsigned n;
    for (n = 0; n < wd * ht && n < 4096; n++) begin
      if ($urandom_range(0, 99) < density)
        send(KIND_WRITE, n, $urandom_range(0, 3), 0, 0, 0, 0);
      else
        send(KIND_WRITE, n, $urandom_range(0, 255), 0, 0, 0, 0);
    end
  endtask

  function logic [21:0] coord_in(int unsigned span);
    if ($urandom_range(0, 19) == 0) return $urandom();
    return $urandom_range(0, span);
  endfunction

  task automatic cast_rand(int unsigned span);
    logic [21:0] ox, oy, tx, ty;
    int unsigned c;
    do begin
      ox = coord_in(span); oy = coord_in(span);
      tx = coord_in(span); ty = coord_in(span);
      case ($urandom_range(0, 7))
        0: tx = ox;
        1: ty = oy;
        2: begin tx = ox; ty = oy; end
        default: ;
      endcase
      c = ray_board.tile_size == 0 ? 256 : ray_board.tile_size << 8;
    end while (!cast_safe(ox, oy, tx, ty, c));
    send(KIND_CAST, $urandom(), $urandom(), ox, oy, tx, ty);
  endtask

  // Every in-map tile the ray may visit must have been written; a cast that
  // could reach an unwritten tile is redrawn.
  function bit cast_safe(logic [21:0] ox, logic [21:0] oy, logic [21:0] tx,
                         logic [21:0] ty, int unsigned c);
    int unsigned x0, x1, y0, y1, x, y;
    x0 = (ox < tx ? ox : tx) / c; x1 = (ox < tx ? tx : ox) / c;
    y0 = (oy < ty ? oy : ty) / c; y1 = (oy < ty ? ty : oy) / c;
    for (y = y0; y <= y1 && y < ray_board.map_height; y++)
      for (x = x0; x <= x1 && x < ray_board.map_width; x++)
        if (y * ray_board.map_width + x < 4096 &&
            !written[y * ray_board.map_width + x]) return 0;
    return 1;
  endfunction

  initial begin
    int unsigned k, ph, wd, ht, ts, span;
    in_ch.valid = 0; in_ch.kind = KIND_WRITE; in_ch.cell_index = 0;
    in_ch.cell_type = 0; in_ch.origin_x = 0; in_ch.origin_y = 0;
    in_ch.target_x = 0; in_ch.target_y = 0;
    ray_board.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed part: small filled map, extremes and special cases.
    write_reg(REG_MAP_WIDTH, 16);
    write_reg(REG_MAP_HEIGHT, 16);
    write_reg(REG_TILE_SIZE, 1);
    write_reg(REG_WALL, 255);
    write_reg(REG_ENEMY_WALL, 0);
    for (k = 0; k < 256; k++) send(KIND_WRITE, k, (k % 7 == 3) ? 255 : 8'hAA, 0, 0, 0, 0);
    send(KIND_WRITE, 4095, 0, 0, 0, 0, 0);
    send(KIND_CAST, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 0, 0);
    send(KIND_CAST, 0, 0, 0, 0, 22'h3FFFFF, 22'h3FFFFF);
    send(KIND_CAST, 0, 0, 3 << 8, 0, 3 << 8, 0);
    send(KIND_CAST, 0, 0, 5, 5, 5, 5);
    send(KIND_CAST, 0, 0, 5, 5, 2000, 5);
    send(KIND_CAST, 0, 0, 5, 5, 5, 2000);
    send(KIND_CAST, 0, 0, 100, 100, 1900, 1900);
    send(KIND_CAST, 0, 0, 16383, 0, 0, 16383);
    drain();
    write_reg(REG_TILE_SIZE, 0);
    send(KIND_CAST, 0, 0, 700, 100, 10, 900);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin wd = 1; ht = 1; ts = 255; end
        1: begin wd = 64; ht = 1; ts = 32; end
        2: begin wd = 127; ht = 127; ts = 1; end
        3: begin wd = 8; ht = 5; ts = 3; end
        default: begin
          wd = $urandom_range(1, 8); ht = $urandom_range(1, 8);
          ts = $urandom_range(1, 40);
        end
      endcase
      write_reg(REG_MAP_WIDTH, wd);
      write_reg(REG_MAP_HEIGHT, ht);
      write_reg(REG_TILE_SIZE, ts);
      write_reg(REG_WALL, ph == 2 ? 255 : $urandom_range(0, 3));
      write_reg(REG_ENEMY_WALL, ph == 0 ? 0 : $urandom_range(0, 3));
      if (wd * ht <= 64) fill_map(wd, ht, 12);
      span = (ts << 8) * (wd > ht ? wd : ht) + 300;
      if (span > 4194303) span = 4194303;
      for (k = 0; k < 90; k++) begin
        if ($urandom_range(0, 9) == 0)
          send(KIND_WRITE, wr_cells[$urandom_range(0, wr_cells.size() - 1)],
               $urandom_range(0, 3), 0, 0, 0, 0);
        else
          cast_rand(span);
      end
      drain();
    end
    if (ray_board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
